// File: rtl/depth_key_sorter_macros.svh
// ---------------------------------------------------------------------------
// Depth key sorter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DEPTH_KEY_SORTER_MACROS_SVH
`define DEPTH_KEY_SORTER_MACROS_SVH

// same-cycle implication
`define DKS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("depth_key_sorter: assertion failed");

// next-cycle implication
`define DKS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("depth_key_sorter: assertion failed");

`endif

// File: rtl/dks_pkg.sv
// ---------------------------------------------------------------------------
// Depth key sorter package
// Transaction types, queue entry type and sizing constants.
// ---------------------------------------------------------------------------
package dks_pkg;

    localparam int KEY_BITS     = 32;
    localparam int HANDLE_BITS  = 16;
    localparam int CAPACITY_DEF = 64;
    localparam int QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic signed [KEY_BITS-1:0]    depth_key;
        logic        [HANDLE_BITS-1:0] object_handle;
        logic                          last_item;
    } dks_item_t;

    typedef struct packed {
        logic signed [KEY_BITS-1:0]    sorted_key;
        logic        [HANDLE_BITS-1:0] sorted_handle;
        logic                          run_end;
        logic                          overflowed;
    } dks_result_t;

    // classified transaction handed from front to back
    typedef struct packed {
        logic signed [KEY_BITS-1:0]    key;
        logic        [HANDLE_BITS-1:0] handle;
        logic                          keep;
        logic                          last;
        logic                          ovf;
    } dks_entry_t;

endpackage

// File: rtl/depth_key_sorter.sv
// ---------------------------------------------------------------------------
// Depth key sorter
// Stable ascending sort of a list of depth keys with object handles.
// ---------------------------------------------------------------------------
// Usage:
//   Drive item with start high; the transaction is taken at an edge where
//   busy is low. last_item marks the end of a list. Up to CAPACITY items are
//   kept per list; further items are dropped and the run is flagged
//   overflowed on every result.
//   Input side: one item per cycle while the four-entry queue has room; the
//   insertion chain takes one queued item per cycle, so busy rises only
//   while a run is being drained and the queue fills up.
//   Output side: done strobes for one cycle per result. The last item
//   passes through the queue into the chain, which sets drain_reg; done is
//   registered from drain_reg, and each transaction still queued ahead of
//   it delays done further. The results follow on consecutive cycles,
//   run_end on the final one. Equal keys come out in arrival order.
//   Draining the chain, one result per cycle, sets the run time.
//   The receiver cannot stall; results must be taken as they appear.
//   Reset empties the queue and the chain; busy is low straight after it.
// ---------------------------------------------------------------------------
module depth_key_sorter #(
    parameter int CAPACITY = dks_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dks_pkg::dks_item_t   item,
    output logic                 done,
    output dks_pkg::dks_result_t result
);
    import dks_pkg::*;

    dks_entry_t push_entry;
    dks_entry_t pop_entry;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    assign busy = full;

    dks_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .full  (full),
        .push  (push),
        .entry (push_entry)
    );

    dks_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_entry),
        .pop     (pop),
        .rd_data (pop_entry),
        .full    (full),
        .empty   (empty)
    );

    dks_sorter #(
        .CAPACITY (CAPACITY)
    ) u_sorter (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .entry  (pop_entry),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

// File: rtl/dks_front.sv
// ---------------------------------------------------------------------------
// Depth key sorter front end
// Accepts transactions, counts the list, marks items to keep or drop.
// ---------------------------------------------------------------------------
module dks_front #(
    parameter int CAPACITY = dks_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  dks_pkg::dks_item_t  item,
    input  logic                full,
    output logic                push,
    output dks_pkg::dks_entry_t entry
);
    import dks_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             keep;

    assign push = start && !full;
    assign keep = (count_reg < CNT_W'(CAPACITY));

    always_comb
    begin
        entry.key    = item.depth_key;
        entry.handle = item.object_handle;
        entry.keep   = keep;
        entry.last   = item.last_item;
        entry.ovf    = ovf_reg || !keep;
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (push)
        begin
            if (item.last_item)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (keep)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// File: rtl/dks_fifo.sv
// ---------------------------------------------------------------------------
// Depth key sorter queue
// Short first-in first-out buffer between front end and sorting chain.
// ---------------------------------------------------------------------------
module dks_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dks_pkg::dks_entry_t wr_data,
    input  logic                pop,
    output dks_pkg::dks_entry_t rd_data,
    output logic                full,
    output logic                empty
);
    import dks_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    dks_entry_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (level_reg == LVL_W'(QUEUE_DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// File: rtl/dks_sorter.sv
// ---------------------------------------------------------------------------
// Depth key sorter back end
// Parallel insertion chain, stable on equal keys, drained one per cycle.
// ---------------------------------------------------------------------------
module dks_sorter #(
    parameter int CAPACITY = dks_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  dks_pkg::dks_entry_t  entry,
    output logic                 pop,
    output logic                 done,
    output dks_pkg::dks_result_t result
);
    import dks_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [KEY_BITS-1:0]    key_reg  [CAPACITY];
    logic signed [KEY_BITS-1:0]    key_next [CAPACITY];
    logic        [HANDLE_BITS-1:0] hdl_reg  [CAPACITY];
    logic        [HANDLE_BITS-1:0] hdl_next [CAPACITY];
    logic        [CAPACITY-1:0]    gt;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             drain_reg;
    logic             drain_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             done_reg;
    dks_result_t      result_reg;
    dks_result_t      result_next;
    logic             ins;

    assign pop    = !empty && !drain_reg;
    assign ins    = pop && entry.keep;
    assign done   = done_reg;
    assign result = result_reg;

    // empty cells count as larger, so the new item lands after all keys <= it
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign gt[i] = (CNT_W'(i) >= cnt_reg) || (key_reg[i] > entry.key);

        if (i == 0)
        begin : g_head
            always_comb
            begin
                key_next[i] = key_reg[i];
                hdl_next[i] = hdl_reg[i];
                if (ins && gt[i])
                begin
                    key_next[i] = entry.key;
                    hdl_next[i] = entry.handle;
                end
                else if (drain_reg)
                begin
                    key_next[i] = key_reg[i+1];
                    hdl_next[i] = hdl_reg[i+1];
                end
            end
        end
        else if (i == CAPACITY - 1)
        begin : g_tail
            always_comb
            begin
                key_next[i] = key_reg[i];
                hdl_next[i] = hdl_reg[i];
                if (ins && gt[i])
                begin
                    key_next[i] = gt[i-1] ? key_reg[i-1] : entry.key;
                    hdl_next[i] = gt[i-1] ? hdl_reg[i-1] : entry.handle;
                end
            end
        end
        else
        begin : g_mid
            always_comb
            begin
                key_next[i] = key_reg[i];
                hdl_next[i] = hdl_reg[i];
                if (ins && gt[i])
                begin
                    key_next[i] = gt[i-1] ? key_reg[i-1] : entry.key;
                    hdl_next[i] = gt[i-1] ? hdl_reg[i-1] : entry.handle;
                end
                else if (drain_reg)
                begin
                    key_next[i] = key_reg[i+1];
                    hdl_next[i] = hdl_reg[i+1];
                end
            end
        end
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        drain_next  = drain_reg;
        ovf_next    = ovf_reg;
        result_next = result_reg;
        if (drain_reg)
        begin
            result_next.sorted_key    = key_reg[0];
            result_next.sorted_handle = hdl_reg[0];
            result_next.run_end       = (cnt_reg == CNT_W'(1));
            result_next.overflowed    = ovf_reg;
            cnt_next                  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                drain_next = 1'b0;
            end
        end
        else if (pop)
        begin
            if (entry.keep)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (entry.last)
            begin
                drain_next = 1'b1;
                ovf_next   = entry.ovf;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        hdl_reg    <= hdl_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            drain_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            drain_reg <= drain_next;
            ovf_reg   <= ovf_next;
            done_reg  <= drain_reg;
        end
    end

endmodule

// File: rtl/dks_checker.sv
// ---------------------------------------------------------------------------
// Depth key sorter checker
// Port-level properties of the sorted run, bound to the top level.
// ---------------------------------------------------------------------------
`include "depth_key_sorter_macros.svh"

module dks_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 done,
    input dks_pkg::dks_result_t result
);
    import dks_pkg::*;

    // a run comes out on consecutive cycles
    `DKS_ASSERT_NEXT(a_run_contiguous, done && !result.run_end, done)

    // keys never decrease within a run
    `DKS_ASSERT_NEXT(a_run_ascending, done && !result.run_end,
        $signed(result.sorted_key) >= $signed($past(result.sorted_key)))

    // overflow flag is the same across the whole run
    `DKS_ASSERT_NEXT(a_run_ovf_steady, done && !result.run_end,
        result.overflowed == $past(result.overflowed))

endmodule

bind depth_key_sorter dks_checker u_dks_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .done   (done),
    .result (result)
);

// File: sim/dks_checker.sv
// ---------------------------------------------------------------------------
// Depth key sorter checker
// Watches both channels of the sorter, predicts each sorted run from the
// accepted transactions and compares every result, field by field, in order.
// ---------------------------------------------------------------------------
module dks_scoreboard #(
    parameter int CAPACITY = dks_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  dks_pkg::dks_item_t   item,
    input  logic                 done,
    input  dks_pkg::dks_result_t result,
    output int                   errors,
    output int                   pending,
    output int                   results_checked,
    output int                   runs_checked,
    output int                   overflow_runs
);
    import dks_pkg::*;

    logic signed [KEY_BITS-1:0]    chain_key [CAPACITY];
    logic        [HANDLE_BITS-1:0] chain_handle [CAPACITY];
    int                            chain_count;
    bit                            dropped;
    dks_result_t                   sorted_q [$];

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        if (errors < 40)
            $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    // stable insertion: the new entry goes after every key <= its own
    task automatic insert_item(input dks_item_t it);
        int          pos;
        dks_result_t entry;
        if (chain_count < CAPACITY)
        begin
            pos = chain_count;
            while (pos > 0 && $signed(chain_key[pos-1]) > $signed(it.depth_key))
            begin
                chain_key[pos]    = chain_key[pos-1];
                chain_handle[pos] = chain_handle[pos-1];
                pos--;
            end
            chain_key[pos]    = it.depth_key;
            chain_handle[pos] = it.object_handle;
            chain_count++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (it.last_item)
        begin
            for (int i = 0; i < chain_count; i++)
            begin
                entry.sorted_key    = chain_key[i];
                entry.sorted_handle = chain_handle[i];
                entry.run_end       = (i == chain_count - 1);
                entry.overflowed    = dropped;
                sorted_q            = {sorted_q, entry};
            end
            chain_count = 0;
            dropped     = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        dks_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (sorted_q.size() == 0)
                begin
                    report("result with nothing expected", 64'(result), '0);
                end
                else
                begin
                    want = sorted_q.pop_front();
                    if (result.sorted_key !== want.sorted_key)
                        report("sorted_key", 64'(result.sorted_key), 64'(want.sorted_key));
                    if (result.sorted_handle !== want.sorted_handle)
                        report("sorted_handle", 64'(result.sorted_handle),
                               64'(want.sorted_handle));
                    if (result.run_end !== want.run_end)
                        report("run_end", 64'(result.run_end), 64'(want.run_end));
                    if (result.overflowed !== want.overflowed)
                        report("overflowed", 64'(result.overflowed), 64'(want.overflowed));
                    results_checked++;
                    if (want.run_end)
                    begin
                        runs_checked++;
                        if (want.overflowed)
                            overflow_runs++;
                    end
                end
            end
            if (start && !busy)
                insert_item(item);
            pending <= sorted_q.size();
        end
    end

endmodule

// File: sim/tb_depth_key_sorter.sv
// ---------------------------------------------------------------------------
// Depth key sorter testbench
// Feeds lists of depth key transactions into the sorter: a directed set of
// extreme keys, single-item lists, equal keys and descending keys, then random
// lists with random gaps, including a full list and an overflowing one. A checker
// beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_depth_key_sorter;
    import dks_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int QUIET_LIMIT  = 2000;
    localparam int ITEM_TARGET  = 170;
    localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};

    typedef enum int { KEYS_FULL, KEYS_CLUSTERED, KEYS_EXTREME } key_style_e;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    dks_item_t   item;
    logic        done;
    dks_result_t result;

    int errors;
    int pending;
    int results_checked;
    int runs_checked;
    int overflow_runs;
    int items_sent;
    int lists_sent;
    int quiet;

    depth_key_sorter #(.CAPACITY(CAPACITY)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    dks_scoreboard #(.CAPACITY(CAPACITY)) u_scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .item            (item),
        .done            (done),
        .result          (result),
        .errors          (errors),
        .pending         (pending),
        .results_checked (results_checked),
        .runs_checked    (runs_checked),
        .overflow_runs   (overflow_runs)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic signed [KEY_BITS-1:0] pick_key(input key_style_e style);
        logic signed [KEY_BITS-1:0] k;
        case (style)
            KEYS_CLUSTERED: k = $signed($urandom_range(0, 8)) - 4;
            KEYS_EXTREME:
                case ($urandom_range(0, 4))
                    0:       k = KEY_MIN;
                    1:       k = KEY_MAX;
                    2:       k = -1;
                    3:       k = 0;
                    default: k = 1;
                endcase
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic send_item(input logic signed [KEY_BITS-1:0] key,
                             input logic [HANDLE_BITS-1:0] handle, input logic last);
        dks_item_t it;
        it.depth_key     = key;
        it.object_handle = handle;
        it.last_item     = last;
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_list(input int len, input key_style_e style, input bit gappy);
        for (int i = 0; i < len; i++)
        begin
            send_item(pick_key(style), HANDLE_BITS'($urandom_range(0, 65535)), i == len - 1);
            if (gappy)
                hold_off($urandom_range(0, 16));
        end
        lists_sent++;
    endtask

    initial
    begin
        int len;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        items_sent = 0;
        lists_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single-item lists pass straight through
        send_item(KEY_MIN, 16'hFFFF, 1'b1);
        send_item(KEY_MAX, 16'h0000, 1'b1);
        // extremes out of order
        send_item(KEY_MAX, 16'h0001, 1'b0);
        send_item(KEY_MIN, 16'h0002, 1'b0);
        send_item(0,       16'h0003, 1'b0);
        send_item(-1,      16'h0004, 1'b0);
        send_item(1,       16'h0005, 1'b1);
        hold_off(5);
        // equal keys keep arrival order
        for (int i = 0; i < 6; i++)
            send_item(7, HANDLE_BITS'(i + 16'hAAA0), 1'b0);
        send_item(-7, 16'h5555, 1'b1);
        // strictly descending keys
        for (int i = 0; i < 4; i++)
            send_item(KEY_BITS'(100 - 30 * i), HANDLE_BITS'(16'h8000 + i), i == 3);
        lists_sent += 5;
        wait_drained();

        // random lists: one exactly full, one overflowing, the rest mostly short
        send_list(CAPACITY, KEYS_FULL, 1'b0);
        send_list(CAPACITY + 1 + $urandom_range(0, 3), KEYS_CLUSTERED, 1'b1);
        wait_drained();
        while (items_sent < ITEM_TARGET)
        begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_list(len, key_style_e'($urandom_range(0, 2)), $urandom_range(0, 2) != 0);
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Sent %0d transactions in %0d lists, directed extremes and equal keys first.",
                 items_sent, lists_sent);
        $display("Checked %0d results in %0d sorted runs, %0d of them overflowed.",
                 results_checked, runs_checked, overflow_runs);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dks_pkg.sv
rtl/dks_front.sv
rtl/dks_fifo.sv
rtl/dks_sorter.sv
rtl/depth_key_sorter.sv
rtl/dks_checker.sv
sim/dks_checker.sv
sim/tb_depth_key_sorter.sv
